// ----- design/esd_pkg.sv -----
package esd_pkg;

	// Decoder modes
	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX   = 2'd2,
		MODE_OCT   = 2'd3
	} mode_t;

	// Characters with a meaning of their own
	localparam logic [7:0] CHR_BSLASH = 8'h5C;
	localparam logic [7:0] CHR_A      = 8'h61;
	localparam logic [7:0] CHR_B      = 8'h62;
	localparam logic [7:0] CHR_F      = 8'h66;
	localparam logic [7:0] CHR_N      = 8'h6E;
	localparam logic [7:0] CHR_R      = 8'h72;
	localparam logic [7:0] CHR_T      = 8'h74;
	localparam logic [7:0] CHR_V      = 8'h76;
	localparam logic [7:0] CHR_X      = 8'h78;
	localparam logic [7:0] CHR_ZERO   = 8'h30;
	localparam logic [7:0] CHR_SEVEN  = 8'h37;
	localparam logic [7:0] CHR_NINE   = 8'h39;
	localparam logic [7:0] CHR_UA     = 8'h41;
	localparam logic [7:0] CHR_UF     = 8'h46;
	localparam logic [7:0] CHR_LF     = 8'h66;

	// Control codes for the letter escapes
	localparam logic [7:0] CODE_BEL = 8'd7;
	localparam logic [7:0] CODE_BS  = 8'd8;
	localparam logic [7:0] CODE_HT  = 8'd9;
	localparam logic [7:0] CODE_LF  = 8'd10;
	localparam logic [7:0] CODE_VT  = 8'd11;
	localparam logic [7:0] CODE_FF  = 8'd12;
	localparam logic [7:0] CODE_CR  = 8'd13;

	// Digits needed to close a run
	localparam logic [1:0] HEX_DIGITS = 2'd3;
	localparam logic [1:0] OCT_EXTRA  = 2'd2;

	// Marker for a byte that is no hex digit
	localparam logic [4:0] NOT_DIGIT = 5'd16;
	localparam logic [4:0] OCT_MAX   = 5'd7;
	localparam logic [4:0] HEX_MAX   = 5'd15;

	// One result waiting at the output
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       out_string_end;
	} slot_t;

	// Hex digit value, or NOT_DIGIT
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [7:0] d;
		d = 8'd0;
		if (b >= CHR_ZERO && b <= CHR_NINE) begin
			d = b - CHR_ZERO;
			return d[4:0];
		end
		if (b >= CHR_UA && b <= CHR_UF) begin
			d = b - CHR_UA + 8'd10;
			return d[4:0];
		end
		if (b >= CHR_A && b <= CHR_LF) begin
			d = b - CHR_A + 8'd10;
			return d[4:0];
		end
		return NOT_DIGIT;
	endfunction

endpackage

// ----- design/esd_if.sv -----
interface esd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_end;

	modport source (output valid, output in_byte, output string_end, input ready);
	modport sink (input valid, input in_byte, input string_end, output ready);
endinterface

interface esd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       out_string_end;

	modport source (output valid, output out_byte, output run_last, output out_string_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input out_string_end,
		output ready);
endinterface

// ----- design/escape_sequence_decoder.sv -----
// Backslash escape decoder for a quoted byte string.
// din carries one raw byte a beat with string_end on the final byte of a
// string; dout carries decoded bytes, run_last on the last byte that one
// input beat yields, and out_string_end on the final decoded byte.
// Each input beat is decoded in the cycle it is accepted and its zero, one
// or two results land in a two-slot output register, so the first result
// is offered in the cycle after acceptance.
// Throughput: one input beat a cycle while each beat yields at most one
// result and dout does not stall; while a beat's two results wait, din
// takes no beat until the first of them is taken. The two-slot output
// register sets this figure.
// A beat is still taken while a single result waits, provided dout takes
// that result in the same cycle. When dout stalls, the held results stay
// and din is held off while any result waits.
// Reset returns the decoder to plain mode with an empty output register.
module escape_sequence_decoder (
	input  logic             clk,
	input  logic             arst_n,
	esd_in_if.sink           din,
	esd_out_if.source        dout
);

	esd_pkg::mode_t mode_q;
	logic [7:0]     acc_q;
	logic [1:0]     dcnt_q;

	esd_pkg::slot_t slot0_q;
	esd_pkg::slot_t slot1_q;
	logic [1:0]     cnt_q;

	esd_pkg::mode_t nmode;
	logic [7:0]     nacc;
	logic [1:0]     ncnt;
	logic [4:0]     hv;
	logic [1:0]     cinc;
	logic           do_plain;
	logic           e0, e1, e2;
	logic [7:0]     v0, v1, v2;
	logic [1:0]     n_res;
	logic [7:0]     r0, r1;
	logic           pop;
	logic           push;
	logic [7:0]     b;

	assign b = din.in_byte;

	// Decode one beat against the current mode
	always_comb begin
		nmode    = mode_q;
		nacc     = acc_q;
		ncnt     = dcnt_q;
		hv       = esd_pkg::hex_value(b);
		cinc     = dcnt_q + 2'd1;
		do_plain = 1'b0;
		e0       = 1'b0;
		v0       = 8'd0;
		e1       = 1'b0;
		v1       = b;
		e2       = 1'b0;
		v2       = 8'd0;

		unique case (mode_q)
			esd_pkg::MODE_PLAIN: begin
				do_plain = 1'b1;
			end
			esd_pkg::MODE_ESC: begin
				nmode = esd_pkg::MODE_PLAIN;
				e0    = 1'b1;
				unique case (b)
					esd_pkg::CHR_A: v0 = esd_pkg::CODE_BEL;
					esd_pkg::CHR_B: v0 = esd_pkg::CODE_BS;
					esd_pkg::CHR_F: v0 = esd_pkg::CODE_FF;
					esd_pkg::CHR_N: v0 = esd_pkg::CODE_LF;
					esd_pkg::CHR_R: v0 = esd_pkg::CODE_CR;
					esd_pkg::CHR_T: v0 = esd_pkg::CODE_HT;
					esd_pkg::CHR_V: v0 = esd_pkg::CODE_VT;
					esd_pkg::CHR_X: begin
						e0    = 1'b0;
						nmode = esd_pkg::MODE_HEX;
						nacc  = 8'd0;
						ncnt  = 2'd0;
					end
					default: begin
						if (b >= esd_pkg::CHR_ZERO && b <= esd_pkg::CHR_SEVEN) begin
							e0    = 1'b0;
							nmode = esd_pkg::MODE_OCT;
							nacc  = {5'd0, b[2:0]};
							ncnt  = 2'd0;
						end else begin
							v0 = b;
						end
					end
				endcase
			end
			esd_pkg::MODE_HEX: begin
				if (hv > esd_pkg::HEX_MAX) begin
					// run ended early: emit value, then treat byte as plain
					e0       = 1'b1;
					v0       = acc_q;
					nmode    = esd_pkg::MODE_PLAIN;
					nacc     = 8'd0;
					ncnt     = 2'd0;
					do_plain = 1'b1;
				end else begin
					nacc = {acc_q[3:0], hv[3:0]};
					ncnt = cinc;
					if (cinc >= esd_pkg::HEX_DIGITS) begin
						e0    = 1'b1;
						v0    = nacc;
						nmode = esd_pkg::MODE_PLAIN;
						nacc  = 8'd0;
						ncnt  = 2'd0;
					end
				end
			end
			esd_pkg::MODE_OCT: begin
				if (hv > esd_pkg::OCT_MAX) begin
					e0       = 1'b1;
					v0       = acc_q;
					nmode    = esd_pkg::MODE_PLAIN;
					nacc     = 8'd0;
					ncnt     = 2'd0;
					do_plain = 1'b1;
				end else begin
					nacc = {acc_q[4:0], hv[2:0]};
					ncnt = cinc;
					if (cinc >= esd_pkg::OCT_EXTRA) begin
						e0    = 1'b1;
						v0    = nacc;
						nmode = esd_pkg::MODE_PLAIN;
						nacc  = 8'd0;
						ncnt  = 2'd0;
					end
				end
			end
			default: begin
				nmode = esd_pkg::MODE_PLAIN;
			end
		endcase

		// Plain byte: open an escape or pass through
		if (do_plain) begin
			if (b == esd_pkg::CHR_BSLASH) begin
				nmode = esd_pkg::MODE_ESC;
			end else begin
				e1 = 1'b1;
			end
		end

		// Flush a pending escape at the end of the string
		if (din.string_end) begin
			if (nmode == esd_pkg::MODE_ESC) begin
				e2 = 1'b1;
				v2 = 8'd0;
			end else if (nmode == esd_pkg::MODE_HEX || nmode == esd_pkg::MODE_OCT) begin
				e2 = 1'b1;
				v2 = nacc;
			end
			nmode = esd_pkg::MODE_PLAIN;
			nacc  = 8'd0;
			ncnt  = 2'd0;
		end
	end

	// Pack the emitted bytes in order
	always_comb begin
		n_res = {1'b0, e0} + {1'b0, e1} + {1'b0, e2};
		r0    = e0 ? v0 : (e1 ? v1 : v2);
		r1    = (e0 && e1) ? v1 : v2;
	end

	// Handshake
	assign pop       = dout.valid && dout.ready;
	assign din.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && dout.ready);
	assign push      = din.valid && din.ready;

	assign dout.valid          = (cnt_q != 2'd0);
	assign dout.out_byte       = slot0_q.out_byte;
	assign dout.run_last       = slot0_q.run_last;
	assign dout.out_string_end = slot0_q.out_string_end;

	// Advance decoder state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= esd_pkg::MODE_PLAIN;
			acc_q  <= 8'd0;
			dcnt_q <= 2'd0;
		end else if (push) begin
			mode_q <= nmode;
			acc_q  <= nacc;
			dcnt_q <= ncnt;
		end
	end

	// Control of the output slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= n_res;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Load new results, or shift the second slot forward on a pop
	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q.out_byte       <= r0;
			slot0_q.run_last       <= (n_res == 2'd1);
			slot0_q.out_string_end <= (n_res == 2'd1) && din.string_end;
			slot1_q.out_byte       <= r1;
			slot1_q.run_last       <= 1'b1;
			slot1_q.out_string_end <= din.string_end;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

endmodule

// ----- tb/testbench.sv -----
module testbench;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_BEATS = 270;

	logic clk;
	logic arst_n;

	esd_in_if  din();
	esd_out_if dout();

	escape_sequence_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout)
	);

	// Decoder state as the predictor sees it
	esd_pkg::mode_t dec_mode;
	logic [7:0]     dec_acc;
	logic [1:0]     dec_cnt;
	logic [7:0]     beat_bytes[2];
	int             beat_n;

	// Decoded bytes still owed by the block, oldest first
	esd_pkg::slot_t decoded_q[$];
	// Raw text waiting to be sent
	logic [7:0]     text_q[$];

	int idle_pct;
	int stall_pct;
	int errors;
	int beats_sent;
	int bytes_checked;
	int ends_sent;
	int cycles;

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Value of a hex digit character, 16 for anything else
	function automatic int digit_value(input logic [7:0] b);
		if (b >= esd_pkg::CHR_ZERO && b <= esd_pkg::CHR_NINE)
			return int'(b) - int'(esd_pkg::CHR_ZERO);
		if (b >= esd_pkg::CHR_UA && b <= esd_pkg::CHR_UF)
			return int'(b) - int'(esd_pkg::CHR_UA) + 10;
		if (b >= esd_pkg::CHR_A && b <= esd_pkg::CHR_LF)
			return int'(b) - int'(esd_pkg::CHR_A) + 10;
		return 16;
	endfunction

	function automatic void owe_byte(input logic [7:0] b);
		if (beat_n < 2) begin
			beat_bytes[beat_n] = b;
			beat_n++;
		end
	endfunction

	function automatic void clear_run();
		dec_mode = esd_pkg::MODE_PLAIN;
		dec_acc = 8'd0;
		dec_cnt = 2'd0;
	endfunction

	function automatic void plain_char(input logic [7:0] b);
		if (b == esd_pkg::CHR_BSLASH) begin
			dec_mode = esd_pkg::MODE_ESC;
		end else begin
			owe_byte(b);
		end
	endfunction

	function automatic void escaped_char(input logic [7:0] b);
		dec_mode = esd_pkg::MODE_PLAIN;
		case (b)
			esd_pkg::CHR_A: owe_byte(esd_pkg::CODE_BEL);
			esd_pkg::CHR_B: owe_byte(esd_pkg::CODE_BS);
			esd_pkg::CHR_F: owe_byte(esd_pkg::CODE_FF);
			esd_pkg::CHR_N: owe_byte(esd_pkg::CODE_LF);
			esd_pkg::CHR_R: owe_byte(esd_pkg::CODE_CR);
			esd_pkg::CHR_T: owe_byte(esd_pkg::CODE_HT);
			esd_pkg::CHR_V: owe_byte(esd_pkg::CODE_VT);
			esd_pkg::CHR_X: begin
				dec_mode = esd_pkg::MODE_HEX;
				dec_acc = 8'd0;
				dec_cnt = 2'd0;
			end
			default: begin
				if (b >= esd_pkg::CHR_ZERO && b <= esd_pkg::CHR_SEVEN) begin
					dec_mode = esd_pkg::MODE_OCT;
					dec_acc = b - esd_pkg::CHR_ZERO;
					dec_cnt = 2'd0;
				end else begin
					owe_byte(b);
				end
			end
		endcase
	endfunction

	// Emit what the run holds, then treat the byte as plain text
	function automatic void break_run(input logic [7:0] b);
		owe_byte(dec_acc);
		clear_run();
		plain_char(b);
	endfunction

	// Work out the decoded bytes that one accepted beat owes
	function automatic void decode_beat(input logic [7:0] b, input logic se);
		int             d;
		esd_pkg::slot_t s;
		beat_n = 0;
		case (dec_mode)
			esd_pkg::MODE_PLAIN: plain_char(b);
			esd_pkg::MODE_ESC:   escaped_char(b);
			esd_pkg::MODE_HEX: begin
				d = digit_value(b);
				if (d > int'(esd_pkg::HEX_MAX)) begin
					break_run(b);
				end else begin
					dec_acc = {dec_acc[3:0], d[3:0]};
					dec_cnt = dec_cnt + 2'd1;
					if (dec_cnt == esd_pkg::HEX_DIGITS) begin
						owe_byte(dec_acc);
						clear_run();
					end
				end
			end
			esd_pkg::MODE_OCT: begin
				d = digit_value(b);
				if (d > int'(esd_pkg::OCT_MAX)) begin
					break_run(b);
				end else begin
					dec_acc = {dec_acc[4:0], d[2:0]};
					dec_cnt = dec_cnt + 2'd1;
					if (dec_cnt == esd_pkg::OCT_EXTRA) begin
						owe_byte(dec_acc);
						clear_run();
					end
				end
			end
		endcase
		// Flush whatever is pending at the end of a string
		if (se) begin
			if (dec_mode == esd_pkg::MODE_ESC) begin
				owe_byte(8'd0);
			end else if (dec_mode == esd_pkg::MODE_HEX || dec_mode == esd_pkg::MODE_OCT) begin
				owe_byte(dec_acc);
			end
			clear_run();
		end
		for (int k = 0; k < beat_n; k++) begin
			s.out_byte = beat_bytes[k];
			s.run_last = (k == beat_n - 1);
			s.out_string_end = (k == beat_n - 1) && se;
			decoded_q.push_back(s);
		end
	endfunction

	// Offer one raw byte, after a random gap, and hold it until taken
	task automatic send_beat(input logic [7:0] b, input logic se);
		while ($urandom_range(1, 100) <= idle_pct) begin
			din.valid = 1'b0;
			@(negedge clk);
		end
		din.valid = 1'b1;
		din.in_byte = b;
		din.string_end = se;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
		decode_beat(b, se);
		beats_sent++;
		if (se) ends_sent++;
		@(negedge clk);
	endtask

	// Receiver: stall at random, drive at the falling edge
	always @(negedge clk) begin
		dout.ready <= ($urandom_range(1, 100) > stall_pct);
	end

	// Check each decoded beat against the oldest one owed
	always @(posedge clk) begin
		esd_pkg::slot_t want;
		if (arst_n && dout.valid && dout.ready) begin
			if (decoded_q.size() == 0) begin
				errors++;
				$display("%0t: decoded byte %02h with none expected", $time, dout.out_byte);
			end else begin
				want = decoded_q.pop_front();
				bytes_checked++;
				if (dout.out_byte !== want.out_byte) begin
					errors++;
					$display("%0t: out_byte expected %02h actual %02h", $time,
						want.out_byte, dout.out_byte);
				end
				if (dout.run_last !== want.run_last) begin
					errors++;
					$display("%0t: run_last expected %0b actual %0b", $time,
						want.run_last, dout.run_last);
				end
				if (dout.out_string_end !== want.out_string_end) begin
					errors++;
					$display("%0t: out_string_end expected %0b actual %0b", $time,
						want.out_string_end, dout.out_string_end);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d decoded bytes outstanding", $time,
				decoded_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Random hex digit character, either case
	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return esd_pkg::CHR_ZERO + 8'(v);
		if ($urandom_range(0, 1)) return esd_pkg::CHR_UA + 8'(v - 10);
		return esd_pkg::CHR_A + 8'(v - 10);
	endfunction

	// Queue one token of text: mostly well-formed escapes, some noise
	function automatic void add_token();
		int         kind;
		int         n;
		logic [7:0] b;
		logic [7:0] letters[7];
		letters = '{esd_pkg::CHR_A, esd_pkg::CHR_B, esd_pkg::CHR_F, esd_pkg::CHR_N,
			esd_pkg::CHR_R, esd_pkg::CHR_T, esd_pkg::CHR_V};
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			text_q.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 38) begin
			b = 8'($urandom_range(0, 255));
			if (b == esd_pkg::CHR_BSLASH) b = esd_pkg::CHR_UA;
			text_q.push_back(b);
		end else if (kind < 55) begin
			text_q.push_back(esd_pkg::CHR_BSLASH);
			text_q.push_back(letters[$urandom_range(0, 6)]);
		end else if (kind < 72) begin
			text_q.push_back(esd_pkg::CHR_BSLASH);
			text_q.push_back(esd_pkg::CHR_X);
			n = $urandom_range(0, 3);
			for (int k = 0; k < n; k++) text_q.push_back(hex_char());
		end else if (kind < 90) begin
			text_q.push_back(esd_pkg::CHR_BSLASH);
			n = $urandom_range(1, 3);
			for (int k = 0; k < n; k++)
				text_q.push_back(esd_pkg::CHR_ZERO + 8'($urandom_range(0, 7)));
		end else begin
			text_q.push_back(esd_pkg::CHR_BSLASH);
			text_q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic test_plain_bytes();
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b1);
	endtask

	task automatic test_letter_escapes();
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(esd_pkg::CHR_N, 1'b0);
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(esd_pkg::CHR_V, 1'b0);
		// nine is no octal digit, so it stands for itself
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(esd_pkg::CHR_NINE, 1'b0);
	endtask

	task automatic test_hex_runs();
		// three digits close the run, value truncated to a byte
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(esd_pkg::CHR_X, 1'b0);
		send_beat(esd_pkg::CHR_UF, 1'b0);
		send_beat(esd_pkg::CHR_LF, 1'b0);
		send_beat(esd_pkg::CHR_UA, 1'b0);
		// run with no digits cut short by a new escape
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(esd_pkg::CHR_X, 1'b0);
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(8'h71, 1'b0);
	endtask

	task automatic test_octal_runs();
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(esd_pkg::CHR_SEVEN, 1'b0);
		send_beat(esd_pkg::CHR_SEVEN, 1'b0);
		send_beat(esd_pkg::CHR_SEVEN, 1'b0);
		// eight ends the run early and then passes through: two bytes
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(esd_pkg::CHR_ZERO + 8'd3, 1'b0);
		send_beat(esd_pkg::CHR_ZERO + 8'd8, 1'b0);
	endtask

	task automatic test_string_end();
		// trailing backslash flushes as zero
		send_beat(esd_pkg::CHR_BSLASH, 1'b1);
		// pending hex value flushed with the final byte
		send_beat(esd_pkg::CHR_BSLASH, 1'b0);
		send_beat(esd_pkg::CHR_X, 1'b0);
		send_beat(esd_pkg::CHR_ZERO + 8'd1, 1'b1);
	endtask

	task automatic test_random_text(input int idle, input int stall, input int beats);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = beats_sent + beats;
		while (beats_sent < target) begin
			add_token();
			while (text_q.size() != 0)
				send_beat(text_q.pop_front(), $urandom_range(0, 19) == 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		din.valid = 1'b0;
		din.in_byte = 8'h00;
		din.string_end = 1'b0;
		dout.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		errors = 0;
		beats_sent = 0;
		bytes_checked = 0;
		ends_sent = 0;
		cycles = 0;
		clear_run();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_plain_bytes();
		test_letter_escapes();
		test_hex_runs();
		test_octal_runs();
		test_string_end();
		test_random_text(0, 0, PHASE_BEATS);
		test_random_text(45, 0, PHASE_BEATS);
		test_random_text(0, 45, PHASE_BEATS);
		test_random_text(33, 33, PHASE_BEATS);

		// Drop valid, drain, then watch for stray beats
		din.valid = 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d raw bytes (%0d string ends), checked %0d decoded bytes",
			beats_sent, ends_sent, bytes_checked);
		$display("Flow control: free, sender gaps, receiver stalls, both; %0d errors", errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
